@@ design/rhhr_pkg.sv @@
package rhhr_pkg;

  // command codes carried in s_tuser
  localparam logic [1:0] CMD_UP   = 2'd0;
  localparam logic [1:0] CMD_DOWN = 2'd1;
  localparam logic [1:0] CMD_COMP = 2'd2;
  localparam logic [1:0] CMD_PASS = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PALE      = 2'd0;
  localparam logic [1:0] CFG_MODERATE  = 2'd1;
  localparam logic [1:0] CFG_SATURATED = 2'd2;

  // step register reset values, Q0.16 of a turn
  localparam logic [15:0] STEP_PALE_RST      = 16'd14564;
  localparam logic [15:0] STEP_MODERATE_RST  = 16'd10082;
  localparam logic [15:0] STEP_SATURATED_RST = 16'd6363;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  cmd;
    rgb_t        pix;
    logic [8:0]  sum;   // max + min
    logic [7:0]  diff;  // max - min
    logic [7:0]  den;   // saturation divisor
    logic [10:0] num;   // hue numerator, below 6 * diff when diff is nonzero
  } pix_class_t;

  // piece of the HSL to RGB channel curve
  typedef enum logic [1:0] {
    CH_RAMP,
    CH_HIGH,
    CH_LOW
  } ch_mode_t;

endpackage

@@ design/rgb_hsl_hue_rotate.sv @@
// RGB pixel hue rotation through HSL.
// Input stream s_*: one pixel word per beat, tdata = red, green, blue from the
// low byte up, tuser = command (up by step, down by step, half turn, pass).
// Output stream m_*: rotated red, green, blue bytes, then rotated hue,
// saturation and lightness as Q0.16, tuser = output equals input.
// Step registers are written through cfg_wdata / cfg_addr / cfg_we, one
// register per cycle. The user must write them only while the stream is
// idle; the block itself does not enforce this. Throughput: one word per
// clock while the output is not stalled. The saturation and hue quotients
// come from a divider pipeline that resolves one quotient bit per stage,
// FRAC_BITS + 1 stages; lightness is a constant reciprocal product carried
// alongside it.
// Reset (rst, synchronous) empties the pipeline and queue and restores the
// default step values. When m_tvalid is high and m_tready low, the back end
// holds, the four-entry queue absorbs the front end, s_tready drops once full.
module rgb_hsl_hue_rotate import rhhr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // red, green, blue, hue, saturation, lightness
  output logic [0:0]  m_tuser,   // same_as_input
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] step_pale, step_moderate, step_saturated;

  // step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_pale      <= STEP_PALE_RST;
      step_moderate  <= STEP_MODERATE_RST;
      step_saturated <= STEP_SATURATED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PALE:      step_pale      <= cfg_wdata;
        CFG_MODERATE:  step_moderate  <= cfg_wdata;
        CFG_SATURATED: step_saturated <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       fr_valid, fr_ready, q_valid, en, dv_valid;
  pix_class_t fr_item, q_item, dv_item;
  logic [FRAC_BITS:0] l_quo, s_quo, h_quo;

  rhhr_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .out_valid(fr_valid), .out_ready(fr_ready), .out_item(fr_item)
  );

  rhhr_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_item),
    .pop_valid(q_valid), .pop_en(en), .pop_data(q_item)
  );

  rhhr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .in_item(q_item),
    .out_valid(dv_valid), .out_item(dv_item),
    .l_quo(l_quo), .s_quo(s_quo), .h_quo(h_quo)
  );

  rhhr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(dv_valid), .in_item(dv_item),
    .l_quo(l_quo), .s_quo(s_quo), .h_quo(h_quo),
    .step_pale(step_pale), .step_moderate(step_moderate),
    .step_saturated(step_saturated),
    .en(en),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

@@ design/rhhr_front.sv @@
module rhhr_front import rhhr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue
  input  logic [1:0]  s_tuser,   // cmd
  output logic        out_valid,
  input  logic        out_ready,
  output pix_class_t  out_item
);

  logic       full_valid;
  pix_class_t item;
  pix_class_t item_next;

  logic [7:0]  r, g, b, mx, mn, d;
  logic [8:0]  sum;
  logic [10:0] d6;

  // min, max and hue sector of the incoming word
  always_comb begin
    r = s_tdata[7:0];
    g = s_tdata[15:8];
    b = s_tdata[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d6  = ({3'b0, d} << 2) + ({3'b0, d} << 1);

    item_next.cmd       = s_tuser;
    item_next.pix.red   = r;
    item_next.pix.green = g;
    item_next.pix.blue  = b;
    item_next.sum       = sum;
    item_next.diff      = d;
    item_next.den       = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    // red wins ties, then green
    if (mx == r) begin
      item_next.num = (g >= b) ? {3'b0, g - b} : d6 - {3'b0, b - g};
    end else if (mx == g) begin
      item_next.num = ({3'b0, d} << 1) + {3'b0, b} - {3'b0, r};
    end else begin
      item_next.num = ({3'b0, d} << 2) + {3'b0, r} - {3'b0, g};
    end
  end

  assign s_tready  = !full_valid || out_ready;
  assign out_valid = full_valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_valid <= 1'b0;
    end else if (s_tready) begin
      full_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

@@ design/rhhr_queue.sv @@
module rhhr_queue import rhhr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  pix_class_t push_data,
  output logic       pop_valid,
  input  logic       pop_en,
  output pix_class_t pop_data
);

  localparam int DEPTH = 4;

  pix_class_t entries [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push, pop;

  assign push_ready = (count != 3'(DEPTH));
  assign pop_valid  = (count != 3'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_en && pop_valid;
  assign pop_data   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      if (push && !pop)      count <= count + 3'd1;
      else if (pop && !push) count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH)) else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 3'd1) else $error("queue push lost");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 3'd1) else $error("queue pop lost");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd0 || count == 3'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

@@ design/rhhr_div.sv @@
module rhhr_div import rhhr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  pix_class_t       in_item,
  output logic             out_valid,
  output pix_class_t       out_item,
  output logic [FRAC_BITS:0] l_quo,
  output logic [FRAC_BITS:0] s_quo,
  output logic [FRAC_BITS:0] h_quo
);

  // one quotient bit per stage: integer bit, then FRAC_BITS fraction bits
  localparam int NS = FRAC_BITS + 1;
  localparam int FW = FRAC_BITS + 1;
  localparam int RW = 12;
  localparam int DW = 11;
  // lightness = sum * 2^(FRAC_BITS-1) / 255 = sum * L_A + sum * L_B / 255
  localparam int L_A = (1 << (FRAC_BITS - 1)) / 255;
  localparam int L_B = (1 << (FRAC_BITS - 1)) % 255;
  // ceil(2^25 / 255), exact floor division by 255 for operands below 2^17
  localparam logic [17:0] L_RECIP = 18'd131587;

  logic [16:0]   l_y;
  logic [34:0]   l_yp;
  logic [FW-1:0] l_val;

  // lanes: 0 saturation, 1 hue
  logic [RW-1:0] rem  [NS][2];
  logic [DW-1:0] dv   [NS][2];
  logic [FW-1:0] quo  [NS][2];
  logic [FW-1:0] lq   [NS];
  logic          vld  [NS];
  pix_class_t    item [NS];

  logic [RW-1:0] c_par [NS][2];
  logic [RW-1:0] c_rem [NS][2];
  logic [DW-1:0] c_dv  [NS][2];
  logic [FW-1:0] c_quo [NS][2];
  logic          c_bit [NS][2];
  logic [FW-1:0] c_lq  [NS];
  logic          c_vld [NS];
  pix_class_t    c_item [NS];

  // lightness by reciprocal multiplication, carried alongside the divider
  always_comb begin
    l_y   = 17'(in_item.sum) * 17'(L_B);
    l_yp  = 35'(l_y) * 35'(L_RECIP);
    l_val = FW'(in_item.sum) * FW'(L_A) + FW'(l_yp[34:25]);
  end

  // stage inputs and one compare-subtract per lane and stage
  always_comb begin
    c_par[0][0] = RW'(in_item.diff);
    c_par[0][1] = RW'(in_item.num);
    c_dv[0][0]  = DW'(in_item.den);
    c_dv[0][1]  = (DW'(in_item.diff) << 2) + (DW'(in_item.diff) << 1);
    c_lq[0]     = l_val;
    c_vld[0]    = in_valid;
    c_item[0]   = in_item;
    for (int j = 0; j < 2; j++) begin
      c_quo[0][j] = '0;
    end
    for (int k = 1; k < NS; k++) begin
      c_vld[k]  = vld[k-1];
      c_item[k] = item[k-1];
      c_lq[k]   = lq[k-1];
      for (int j = 0; j < 2; j++) begin
        c_par[k][j] = {rem[k-1][j][RW-2:0], 1'b0};
        c_dv[k][j]  = dv[k-1][j];
        c_quo[k][j] = quo[k-1][j];
      end
    end
    for (int k = 0; k < NS; k++) begin
      for (int j = 0; j < 2; j++) begin
        c_bit[k][j] = c_par[k][j] >= {1'b0, c_dv[k][j]};
        c_rem[k][j] = c_bit[k][j] ? c_par[k][j] - {1'b0, c_dv[k][j]} : c_par[k][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NS; k++) vld[k] <= c_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        item[k] <= c_item[k];
        lq[k]   <= c_lq[k];
        for (int j = 0; j < 2; j++) begin
          rem[k][j] <= c_rem[k][j];
          dv[k][j]  <= c_dv[k][j];
          quo[k][j] <= {c_quo[k][j][FW-2:0], c_bit[k][j]};
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_item  = item[NS-1];
  assign l_quo     = lq[NS-1];
  assign s_quo     = quo[NS-1][0];
  assign h_quo     = quo[NS-1][1];

endmodule

@@ design/rhhr_back.sv @@
module rhhr_back import rhhr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pix_class_t         in_item,
  input  logic [FRAC_BITS:0] l_quo,
  input  logic [FRAC_BITS:0] s_quo,
  input  logic [FRAC_BITS:0] h_quo,
  input  logic [15:0]        step_pale,
  input  logic [15:0]        step_moderate,
  input  logic [15:0]        step_saturated,
  output logic               en,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,   // red, green, blue, hue, saturation, lightness
  output logic [0:0]         m_tuser    // same_as_input
);

  localparam int F     = FRAC_BITS;
  localparam int W     = F + 4;
  localparam int UP_SH = (F >= 16) ? F - 16 : 0;
  localparam int DN_SH = (F < 16) ? 16 - F : 0;
  localparam logic [W-1:0] ONE   = W'(1) << F;
  localparam logic [W-1:0] THIRD = ONE / 3;
  localparam logic [F-1:0] HALF_TURN = F'(1) << (F - 1);
  localparam logic [F+10:0] HALF_B = (F + 11)'(1) << (F - 1);

  function automatic logic [15:0] q16_sat(input logic [F:0] x);
    logic [F+16:0] w;
    w = ((F + 17)'(x) >> UP_SH) << DN_SH;
    return (w > (F + 17)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  // falling ramp factor 4 - 6t
  function automatic logic [F:0] s2_fac_dn(input logic [W-1:0] six);
    logic [W-1:0] w;
    w = (ONE << 2) - six;
    return w[F:0];
  endfunction

  assign en = !m_tvalid || m_tready;

  // stage 1: step choice, rotation, L*S
  logic [F:0]     s1_l, s1_s;
  logic [F-1:0]   s1_h, s1_hr, s1_step;
  logic [15:0]    s1_step16;
  logic [F+15:0]  s1_stw;
  logic [W-1:0]   s1_lw, s1_sw;
  logic [2*F+1:0] s1_ls;
  logic           s1_pale, s1_mod;

  always_comb begin
    s1_l  = l_quo;
    s1_s  = (in_item.diff == 8'd0) ? '0 : s_quo;
    s1_h  = (in_item.diff == 8'd0) ? '0 : h_quo[F-1:0];
    s1_lw = W'(s1_l);
    s1_sw = W'(s1_s);
    s1_pale = ((s1_lw << 2) + s1_lw >= (ONE << 2)) ||
              (((s1_sw << 3) + (s1_sw << 1)) < ((ONE << 1) + ONE));
    s1_mod  = ((s1_lw << 1) >= ONE) || ((s1_sw << 1) < ONE);
    if (s1_pale)     s1_step16 = step_pale;
    else if (s1_mod) s1_step16 = step_moderate;
    else             s1_step16 = step_saturated;
    s1_stw  = ((F + 16)'(s1_step16) << UP_SH) >> DN_SH;
    s1_step = s1_stw[F-1:0];
    case (in_item.cmd)
      CMD_UP:   s1_hr = s1_h + s1_step;
      CMD_DOWN: s1_hr = s1_h - s1_step;
      CMD_COMP: s1_hr = s1_h + HALF_TURN;
      CMD_PASS: s1_hr = s1_h;
      default:  s1_hr = s1_h;
    endcase
    s1_ls = s1_l * s1_s;
  end

  logic         b1_v;
  logic [F-1:0] b1_hr;
  logic [F:0]   b1_l, b1_s, b1_ls;
  rgb_t         b1_pix;

  // stage 2: p, q, channel hues and curve pieces
  logic [W-1:0] s2_lw, s2_sw, s2_lsw, s2_q, s2_p, s2_hw;
  logic [W-1:0] s2_t   [3];
  logic [W-1:0] s2_six [3];
  logic [F:0]   s2_fac [3];
  ch_mode_t     s2_mode [3];

  always_comb begin
    s2_lw  = W'(b1_l);
    s2_sw  = W'(b1_s);
    s2_lsw = W'(b1_ls);
    s2_q = ((s2_lw << 1) < ONE) ? s2_lw + s2_lsw : s2_lw + s2_sw - s2_lsw;
    s2_p = ((s2_lw << 1) > s2_q) ? (s2_lw << 1) - s2_q : '0;
    if (s2_q < s2_p) s2_q = s2_p;
    s2_hw   = W'(b1_hr);
    s2_t[0] = s2_hw + THIRD;
    if (s2_t[0] >= ONE) s2_t[0] = s2_t[0] - ONE;
    s2_t[1] = s2_hw;
    s2_t[2] = s2_hw + ONE - THIRD;
    if (s2_t[2] >= ONE) s2_t[2] = s2_t[2] - ONE;
    for (int c = 0; c < 3; c++) begin
      s2_six[c] = (s2_t[c] << 2) + (s2_t[c] << 1);
      if (s2_six[c] < ONE) begin
        s2_mode[c] = CH_RAMP;
        s2_fac[c]  = s2_six[c][F:0];
      end else if ((s2_t[c] << 1) < ONE) begin
        s2_mode[c] = CH_HIGH;
        s2_fac[c]  = '0;
      end else if ((s2_t[c] << 1) + s2_t[c] < (ONE << 1)) begin
        s2_mode[c] = CH_RAMP;
        s2_fac[c]  = s2_fac_dn(s2_six[c]);
      end else begin
        s2_mode[c] = CH_LOW;
        s2_fac[c]  = '0;
      end
    end
  end

  logic         b2_v;
  logic [F+1:0] b2_qp, b2_p, b2_q;
  logic [F:0]   b2_fac [3];
  ch_mode_t     b2_mode [3];
  logic [F-1:0] b2_hr;
  logic [F:0]   b2_l, b2_s;
  rgb_t         b2_pix;

  // stage 3: ramp products
  logic         b3_v;
  logic [2*F+2:0] b3_prod [3];
  logic [F+1:0] b3_p, b3_q;
  ch_mode_t     b3_mode [3];
  logic [F-1:0] b3_hr;
  logic [F:0]   b3_l, b3_s;
  rgb_t         b3_pix;

  // stage 4: channel value and rounding to a byte
  logic [F+1:0]  s4_v  [3];
  logic [F+10:0] s4_x  [3];
  logic [7:0]    s4_c  [3];
  logic          s4_same;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (b3_mode[c])
        CH_RAMP: s4_v[c] = b3_p + b3_prod[c][2*F+1:F];
        CH_HIGH: s4_v[c] = b3_q;
        CH_LOW:  s4_v[c] = b3_p;
        default: s4_v[c] = b3_p;
      endcase
      s4_x[c] = ((F + 11)'(s4_v[c]) << 8) - (F + 11)'(s4_v[c]) + HALF_B;
      s4_c[c] = (s4_x[c][F+10:F] > 11'd255) ? 8'd255 : s4_x[c][F+7:F];
    end
    s4_same = (s4_c[0] == b3_pix.red) && (s4_c[1] == b3_pix.green) &&
              (s4_c[2] == b3_pix.blue);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v     <= 1'b0;
      b2_v     <= 1'b0;
      b3_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      b1_v     <= in_valid;
      b2_v     <= b1_v;
      b3_v     <= b2_v;
      m_tvalid <= b3_v;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      b1_hr  <= s1_hr;
      b1_l   <= s1_l;
      b1_s   <= s1_s;
      b1_ls  <= s1_ls[2*F:F];
      b1_pix <= in_item.pix;

      b2_qp  <= (F + 2)'(s2_q - s2_p);
      b2_p   <= (F + 2)'(s2_p);
      b2_q   <= (F + 2)'(s2_q);
      b2_hr  <= b1_hr;
      b2_l   <= b1_l;
      b2_s   <= b1_s;
      b2_pix <= b1_pix;
      for (int c = 0; c < 3; c++) begin
        b2_fac[c]  <= s2_fac[c];
        b2_mode[c] <= s2_mode[c];
      end

      for (int c = 0; c < 3; c++) begin
        b3_prod[c] <= b2_qp * b2_fac[c];
        b3_mode[c] <= b2_mode[c];
      end
      b3_p   <= b2_p;
      b3_q   <= b2_q;
      b3_hr  <= b2_hr;
      b3_l   <= b2_l;
      b3_s   <= b2_s;
      b3_pix <= b2_pix;

      m_tdata <= {q16_sat(b3_l), q16_sat(b3_s), q16_sat({1'b0, b3_hr}),
                  s4_c[2], s4_c[1], s4_c[0]};
      m_tuser <= s4_same;
    end
  end

endmodule

@@ tb/tb_rgb_hsl_hue_rotate.sv @@
module tb_rgb_hsl_hue_rotate;
  import rhhr_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 7;
  localparam longint ONE = 64'd1 << FB;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        same;
    logic [15:0] light;
    logic [15:0] sat;
    logic [15:0] hue;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } hsl_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_UP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_PALE;
  logic [15:0] cfg_wdata = '0;

  // predictor copy of the step registers
  logic [15:0] step_pale, step_mod, step_sat;

  hsl_word_t rotated_q[$];
  int        err_cnt = 0;
  longint    cyc = 0;
  bit        hold_off = 1'b0;
  bit        rx_busy = 1'b1;

  rgb_hsl_hue_rotate #(.FRAC_BITS(FB)) i_dut (.*);

  always #1 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // HSL curve for one channel hue
  function automatic longint curve(longint p, longint q, longint t);
    if (t < 0) t += ONE;
    if (t >= ONE) t -= ONE;
    if (6 * t < ONE) return p + (((q - p) * (6 * t)) >> FB);
    if (2 * t < ONE) return q;
    if (3 * t < 2 * ONE) return p + (((q - p) * (4 * ONE - 6 * t)) >> FB);
    return p;
  endfunction

  function automatic logic [7:0] to_byte(longint v);
    longint c;
    c = (v * 255 + ONE / 2) >> FB;
    return c > 255 ? 8'd255 : c[7:0];
  endfunction

  function automatic hsl_word_t rotate_pixel(logic [1:0] cmd, rgb_t px);
    hsl_word_t w;
    longint r, g, b, mx, mn, d, sum, l, s, h, n, stp, hr, ls, q, p;
    r = px.red; g = px.green; b = px.blue;
    mx = r; mn = r; s = 0; h = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    l = (sum << FB) / 510;
    if (d != 0) begin
      s = sum < 255 ? (d << FB) / sum : (d << FB) / (510 - sum);
      if (mx == r) n = (g >= b) ? g - b : 6 * d - (b - g);
      else if (mx == g) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      h = (n << FB) / (6 * d);
    end
    if (5 * l >= 4 * ONE || 10 * s < 3 * ONE) stp = step_pale;
    else if (2 * l >= ONE || 2 * s < ONE) stp = step_mod;
    else stp = step_sat;
    case (cmd)
      CMD_UP:   hr = (h + stp) % ONE;
      CMD_DOWN: hr = (h + ONE - stp) % ONE;
      CMD_COMP: hr = (h + ONE / 2) % ONE;
      default:  hr = h;
    endcase
    if (s == 0) begin
      w.red = to_byte(l); w.green = w.red; w.blue = w.red;
    end else begin
      ls = (l * s) >> FB;
      q = (2 * l < ONE) ? l + ls : l + s - ls;
      p = (2 * l > q) ? 2 * l - q : 0;
      if (q < p) q = p;
      w.red = to_byte(curve(p, q, hr + ONE / 3));
      w.green = to_byte(curve(p, q, hr));
      w.blue = to_byte(curve(p, q, hr - ONE / 3));
    end
    w.hue = hr[15:0];
    w.sat = s > 65535 ? 16'hFFFF : s[15:0];
    w.light = l > 65535 ? 16'hFFFF : l[15:0];
    w.same = (w.red == px.red && w.green == px.green && w.blue == px.blue);
    return w;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // send one pixel word, predict on accept; valid stays up until a gap or drain
  task automatic send_pixel(logic [1:0] cmd, rgb_t px, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {px.blue, px.green, px.red};
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rotated_q.push_back(rotate_pixel(cmd, px));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_step(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PALE:     step_pale = val;
      CFG_MODERATE: step_mod = val;
      CFG_SATURATED: step_sat = val;
      default: ;
    endcase
  endtask

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px = 24'($urandom);
    case ($urandom_range(0, 5))
      0: begin px.green = px.red; px.blue = px.red; end
      1: px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return px;
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_busy || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 9) < 7);
  end

  // compare results against predictions
  always @(posedge clk) begin
    hsl_word_t got, exp_w;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (rotated_q.size() == 0) begin
        $error("unexpected word %h", got);
        err_cnt++;
      end else begin
        exp_w = rotated_q.pop_front();
        if (got.red != exp_w.red)
          begin $error("red_out exp %0d got %0d", exp_w.red, got.red); err_cnt++; end
        if (got.green != exp_w.green)
          begin $error("green_out exp %0d got %0d", exp_w.green, got.green); err_cnt++; end
        if (got.blue != exp_w.blue)
          begin $error("blue_out exp %0d got %0d", exp_w.blue, got.blue); err_cnt++; end
        if (got.hue != exp_w.hue)
          begin $error("hue_out exp %0d got %0d", exp_w.hue, got.hue); err_cnt++; end
        if (got.sat != exp_w.sat)
          begin $error("saturation exp %0d got %0d", exp_w.sat, got.sat); err_cnt++; end
        if (got.light != exp_w.light)
          begin $error("lightness exp %0d got %0d", exp_w.light, got.light); err_cnt++; end
        if (got.same != exp_w.same)
          begin $error("same_as_input exp %0d got %0d", exp_w.same, got.same); err_cnt++; end
      end
    end
  end

  // extremes, grays, primaries, every command
  task automatic test_directed();
    rgb_t corners[8];
    corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                24'h808080, 24'h01FE7F, 24'hFF00FF};
    foreach (corners[i]) send_pixel(2'(i % 4), corners[i], 1'b0);
    for (int c = 0; c < 4; c++) begin
      send_pixel(2'(c), 24'h3366CC, 1'b0);
      send_pixel(2'(c), 24'hF0E0D0, 1'b0);
      send_pixel(2'(c), 24'h7F7F80, 1'b0);
    end
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pixel(2'($urandom), rand_pixel(), 1'b1);
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 60; i++) send_pixel(2'($urandom), rand_pixel(), 1'b0);
        drain();
      end
    join
  endtask

  task automatic test_steps(logic [15:0] a, logic [15:0] b, logic [15:0] c, int count);
    write_step(CFG_PALE, a);
    write_step(CFG_MODERATE, b);
    write_step(CFG_SATURATED, c);
    test_random(count);
    drain();
  endtask

  initial begin
    step_pale = STEP_PALE_RST;
    step_mod = STEP_MODERATE_RST;
    step_sat = STEP_SATURATED_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rx_busy = 1'b0;
    test_directed();
    test_random(500);
    drain();
    test_backpressure();
    test_steps(16'h0000, 16'hFFFF, 16'h8000, 300);
    test_steps(16'hFFFF, 16'h0000, 16'h0001, 300);
    test_steps(16'h5555, 16'hAAAA, 16'hFFFF, 300);
    test_steps(STEP_PALE_RST, STEP_MODERATE_RST, STEP_SATURATED_RST, 200);
    drain();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
